/* src/cfd_pkg.sv */
package cfd_pkg;

	localparam int unsigned FRAME_CAPACITY_DEF = 64;
	localparam int unsigned HDR_DEPTH = 6;
	localparam int unsigned HDR_IDX_W = 3;
	localparam int unsigned FILL_W = 7;
	localparam int unsigned POS_W = 6;
	localparam int unsigned NEED_W = 4;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_IDX_W = 1;
	localparam int unsigned QUEUE_CNT_W = 2;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [FILL_W-1:0] KEEP_ALIVE_LEN = 7'd3;

	// byte plus the backslash flag the front end works out for it
	typedef struct packed {
		logic [7:0] data;
		logic is_bs;
	} cfd_item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} cfd_q_status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic stored;
		logic [POS_W-1:0] position;
		logic frame_end;
		logic keep_alive;
		logic [FILL_W-1:0] frame_length;
		logic overflow;
	} cfd_result_t;

	// fixed frame length of a known two-letter command, zero if unknown
	function automatic logic [NEED_W-1:0] cmd_length(input logic [7:0] c1, input logic [7:0] c2);
		logic [NEED_W-1:0] len;
		case ({c1, c2})
			"CT", "HB", "SM": len = 4'd9;
			"ES", "RC", "DL", "NM", "RM": len = 4'd7;
			"UC": len = 4'd14;
			"CA": len = 4'd12;
			"DA", "LA", "RT": len = 4'd8;
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage

/* src/command_frame_delimiter.sv */
// Command frame delimiter: takes one byte per item and returns one result item per byte,
// echoing the byte with whether it was stored, its position in the frame, and frame-end,
// keep-alive and overflow marks. Frames end on a backslash, which for a known '/TA' command
// counts only once its fixed length is reached, or as a three-zero keep-alive; a full frame
// drops the next byte and discards up to a backslash. One item is taken every cycle while
// the queue is not full: the front end classifies the byte and writes a two-entry queue,
// the back end pops it while the output is free, updates the frame state and loads the
// output register; each byte passes a queue entry and then the output register. A stalled
// output holds its result; the queue then takes two more items before the input stalls.
module command_frame_delimiter #(
	parameter int unsigned FRAME_CAPACITY = cfd_pkg::FRAME_CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        stored,
	output logic [cfd_pkg::POS_W-1:0]   position,
	output logic                        frame_end,
	output logic                        keep_alive,
	output logic [cfd_pkg::FILL_W-1:0]  frame_length,
	output logic                        overflow
);

	cfd_pkg::cfd_q_status_t q_status;
	cfd_pkg::cfd_item_t push_item;
	cfd_pkg::cfd_item_t pop_item;
	cfd_pkg::cfd_result_t result;
	logic push;
	logic pop;

	cfd_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.q_status (q_status),
		.push     (push),
		.push_item(push_item)
	);

	cfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.q_status (q_status)
	);

	cfd_back #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop_item (pop_item),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result)
	);

	assign out_byte = result.out_byte;
	assign stored = result.stored;
	assign position = result.position;
	assign frame_end = result.frame_end;
	assign keep_alive = result.keep_alive;
	assign frame_length = result.frame_length;
	assign overflow = result.overflow;

	a_end_is_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> stored && frame_length == {1'b0, position} + 1'b1)
		else $error("frame end on a byte that was not stored at the last position");

	a_keep_alive_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keep_alive |-> frame_end && frame_length == cfd_pkg::KEEP_ALIVE_LEN)
		else $error("keep-alive without a three-byte frame end");

	a_overflow_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !stored && !frame_end)
		else $error("overflow on a stored byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({out_byte, stored, position,
		frame_end, keep_alive, frame_length, overflow}))
		else $error("stalled result item changed or dropped");

endmodule

/* src/cfd_front.sv */
module cfd_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  cfd_pkg::cfd_q_status_t q_status,
	output logic                  push,
	output cfd_pkg::cfd_item_t    push_item
);

	assign in_stall = q_status.full;
	assign push = in_valid && !q_status.full;

	always_comb begin
		push_item.data = data_byte;
		push_item.is_bs = (data_byte == cfd_pkg::CH_BACKSLASH);
	end

endmodule

/* src/cfd_queue.sv */
module cfd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cfd_pkg::cfd_item_t     push_item,
	input  logic                   pop,
	output cfd_pkg::cfd_item_t     pop_item,
	output cfd_pkg::cfd_q_status_t q_status
);

	cfd_pkg::cfd_item_t entry_q [cfd_pkg::QUEUE_DEPTH];
	logic [cfd_pkg::QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [cfd_pkg::QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [cfd_pkg::QUEUE_CNT_W-1:0] count_q;

	assign q_status.full = (count_q == cfd_pkg::QUEUE_CNT_W'(cfd_pkg::QUEUE_DEPTH));
	assign q_status.not_empty = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/cfd_back.sv */
module cfd_back #(
	parameter int unsigned FRAME_CAPACITY = cfd_pkg::FRAME_CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfd_pkg::cfd_q_status_t q_status,
	input  cfd_pkg::cfd_item_t    pop_item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output cfd_pkg::cfd_result_t  result
);

	logic [7:0] hdr_q [cfd_pkg::HDR_DEPTH];
	logic [cfd_pkg::FILL_W-1:0] fill_q;
	logic discarding_q;
	logic out_valid_q;
	cfd_pkg::cfd_result_t result_q;

	logic [7:0] hdr_eff [cfd_pkg::HDR_DEPTH];
	logic [cfd_pkg::FILL_W-1:0] fill_inc;
	logic [cfd_pkg::NEED_W-1:0] need;
	logic is_full;
	logic fixed_done;
	logic delim_done;
	logic is_ka;
	cfd_pkg::cfd_result_t res_next;

	assign pop = q_status.not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result = result_q;

	assign is_full = (fill_q >= cfd_pkg::FILL_W'(FRAME_CAPACITY));
	assign fill_inc = fill_q + 1'b1;

	// header as it stands once the current byte is written
	always_comb begin
		for (int i = 0; i < cfd_pkg::HDR_DEPTH; i++) begin
			hdr_eff[i] = (fill_q == cfd_pkg::FILL_W'(i)) ? pop_item.data : hdr_q[i];
		end
	end

	always_comb begin
		need = '0;
		if (fill_inc >= cfd_pkg::FILL_W'(cfd_pkg::HDR_DEPTH) && hdr_eff[0] == cfd_pkg::CH_SLASH &&
				hdr_eff[1] == cfd_pkg::CH_T && hdr_eff[2] == cfd_pkg::CH_A) begin
			need = cfd_pkg::cmd_length(hdr_eff[4], hdr_eff[5]);
		end
	end

	assign fixed_done = (need != '0) && (fill_inc >= cfd_pkg::FILL_W'(need));
	assign delim_done = pop_item.is_bs && ((need == '0) || fixed_done);
	assign is_ka = (fill_inc == cfd_pkg::KEEP_ALIVE_LEN) && (hdr_eff[0] == 8'h00) &&
		(hdr_eff[1] == 8'h00) && (hdr_eff[2] == 8'h00);

	always_comb begin
		res_next = '0;
		res_next.out_byte = pop_item.data;
		if (!discarding_q) begin
			if (is_full) begin
				res_next.overflow = 1'b1;
			end else begin
				res_next.stored = 1'b1;
				res_next.position = fill_q[cfd_pkg::POS_W-1:0];
				if (delim_done || is_ka) begin
					res_next.frame_end = 1'b1;
					res_next.keep_alive = is_ka;
					res_next.frame_length = fill_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_next;
			if (!discarding_q && !is_full && fill_q < cfd_pkg::FILL_W'(cfd_pkg::HDR_DEPTH)) begin
				hdr_q[fill_q[cfd_pkg::HDR_IDX_W-1:0]] <= pop_item.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			discarding_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (discarding_q) begin
					// drop until the closing backslash
					if (pop_item.is_bs) begin
						discarding_q <= 1'b0;
					end
				end else if (is_full) begin
					fill_q <= '0;
					discarding_q <= !pop_item.is_bs;
				end else if (delim_done || is_ka) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_inc;
				end
			end
		end
	end

endmodule
